/* hdl/keyed_trie_order_sum_engine_macros.svh */
// assertion helpers used by the engine back end
`ifndef KEYED_TRIE_ORDER_SUM_ENGINE_MACROS_SVH
`define KEYED_TRIE_ORDER_SUM_ENGINE_MACROS_SVH

// same-cycle implication
`define KTOSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ktose assertion failed");

// next-cycle implication
`define KTOSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ktose assertion failed");

`endif

/* hdl/ktose_pkg.sv */
package ktose_pkg;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 8;
    localparam int POS_W    = 20;
    localparam int WEIGHT_W = 63;
    localparam int RANGE_W  = 21;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 32;
    localparam int ROOT_W   = 12;   // holds any root index up to the largest key count
    localparam int XW       = 40;   // walk operand, wide enough for rank drift
    localparam int XIW      = 6;    // bit index into a walk operand

    localparam logic [ACTION_W-1:0] ACT_INSERT   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POS_SUM  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RANK_SUM = 2'd2;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_INSERT,
        OP_POS,
        OP_RANK
    } t_op;

    typedef struct packed {
        t_op                         op;
        logic [ROOT_W-1:0]           root;
        logic [XW-1:0]               x_a;     // insert position, or upper prefix bound
        logic [XW-1:0]               x_b;     // lower prefix bound
        logic signed [VALUE_W-1:0]   weight;
    } t_cmd;

endpackage

/* hdl/ktose_in_if.sv */
interface ktose_in_if import ktose_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic [KEY_W-1:0]           key;
    logic [POS_W-1:0]           position;
    logic signed [WEIGHT_W-1:0] weight;
    logic [RANGE_W-1:0]         range_low;
    logic [RANGE_W-1:0]         range_high;

    modport source (output valid, action, key, position, weight, range_low, range_high,
                    input ready);
    modport sink (input valid, action, key, position, weight, range_low, range_high,
                  output ready);
endinterface

/* hdl/ktose_out_if.sv */
interface ktose_out_if import ktose_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] result_value;
    logic                      status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

/* hdl/keyed_trie_order_sum_engine.sv */
// channel   dir   handshake        payload
// i_req     in    valid / ready    action, key, position, weight, range_low, range_high
// o_rsp     out   valid / ready    result_value, status
//
// insert: search walk, pool check, update walk
// query: two prefix walks over the node memory, which has a single
//   read port (a left-sum read adds one more read at that level)
// after reset a clearing pass zeroes the roots; no transaction
//   is taken meanwhile
// a two-entry queue takes transactions while the back end works or o_rsp stalls
module keyed_trie_order_sum_engine import ktose_pkg::*; #(
    parameter int KEY_COUNT     = 256,
    parameter int POOL_NODES    = 65536,
    parameter int POSITION_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ktose_in_if.sink    i_req,
    ktose_out_if.source o_rsp
);

    // front to queue
    logic push;
    t_cmd push_cmd;
    logic q_full;
    // queue to back
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;
    // back end status: roots cleared, transactions may enter
    logic clear_done;

    // classify each transaction: root selection, walk bounds, weight extension
    ktose_front #(
        .KEY_COUNT (KEY_COUNT)
    ) u_front (
        .i_req        (i_req),
        .i_clear_done (clear_done),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // decouples acceptance from the trie walks
    ktose_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // node pool memory and the walk sequencer, with the output register
    ktose_back #(
        .KEY_COUNT     (KEY_COUNT),
        .POOL_NODES    (POOL_NODES),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_valid),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .o_clear_done (clear_done),
        .o_rsp        (o_rsp)
    );

endmodule

/* hdl/ktose_front.sv */
module ktose_front import ktose_pkg::*; #(
    parameter int KEY_COUNT = 256
) (
    ktose_in_if.sink i_req,
    input  logic     i_clear_done,
    input  logic     i_q_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    // key to root map, built at elaboration, key modulo key count
    function automatic logic [2**KEY_W-1:0][KEY_W-1:0] build_root_map();
        logic [2**KEY_W-1:0][KEY_W-1:0] map;
        for (int j = 0; j < 2**KEY_W; j++) begin
            map[j] = KEY_W'(j % KEY_COUNT);
        end
        return map;
    endfunction

    localparam logic [2**KEY_W-1:0][KEY_W-1:0] ROOT_MAP = build_root_map();

    assign i_req.ready = i_clear_done && !i_q_full;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        o_cmd.root   = ROOT_W'(ROOT_MAP[i_req.key]);
        o_cmd.weight = {i_req.weight[WEIGHT_W-1], i_req.weight};
        o_cmd.x_a    = XW'(i_req.range_high) + XW'(1);
        o_cmd.x_b    = XW'(i_req.range_low);
        unique case (i_req.action)
            ACT_INSERT: begin
                o_cmd.op  = OP_INSERT;
                o_cmd.x_a = XW'(i_req.position);
            end
            ACT_POS_SUM:  o_cmd.op = OP_POS;
            ACT_RANK_SUM: o_cmd.op = OP_RANK;
            default:      o_cmd.op = OP_NOP;
        endcase
    end

endmodule

/* hdl/ktose_queue.sv */
module ktose_queue import ktose_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* hdl/ktose_back.sv */
module ktose_back import ktose_pkg::*; #(
    parameter int KEY_COUNT     = 256,
    parameter int POOL_NODES    = 65536,
    parameter int POSITION_BITS = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clear_done,
    ktose_out_if.source o_rsp
);

`include "keyed_trie_order_sum_engine_macros.svh"

    localparam int NW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POSITION_BITS + 1);

    typedef struct packed {
        logic [NW-1:0]      left;
        logic [NW-1:0]      right;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] sum;
    } t_node;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_NODE,
        S_LEFT,
        S_CHECK,
        S_UPD,
        S_DONE
    } t_state;

    t_node mem [POOL_NODES];
    t_node r_rd;

    t_state                r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [NW-1:0]         r_clr, n_clr;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic signed [XW-1:0]  r_x, n_x;
    logic [VALUE_W-1:0]    r_acc, n_acc;
    logic [VALUE_W-1:0]    r_first, n_first;
    logic                  r_second, n_second;
    logic [NW-1:0]         r_right, n_right;
    logic                  r_top, n_top;
    logic [NW-1:0]         r_addr, n_addr;
    logic                  r_fresh, n_fresh;
    logic [NW:0]           r_free, n_free;
    logic [LW-1:0]         r_missing, n_missing;
    logic [VALUE_W-1:0]    r_value, n_value;
    logic                  r_status, n_status;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]    r_out_value, n_out_value;
    logic                  r_out_status, n_out_status;

    logic                  rd_en;
    logic [NW-1:0]         rd_addr;
    logic                  w_en;
    logic [NW-1:0]         w_addr;
    t_node                 w_data;
    logic                  fin;
    logic [VALUE_W-1:0]    fin_acc;
    logic                  adv;
    logic [NW-1:0]         adv_addr;

    logic [XIW-1:0]        bit_idx;
    logic                  bsel;
    logic [NW-1:0]         nxt;
    logic [NW-1:0]         root;
    logic signed [XW-1:0]  lc;
    t_node                 nd;
    t_node                 upd;
    logic [NW-1:0]         ch;
    logic [COUNT_W-1:0]    step;

    assign bit_idx  = XIW'(r_lvl) - XIW'(1);
    assign bsel     = r_x[bit_idx];
    assign nxt      = bsel ? r_rd.right : r_rd.left;
    assign root     = NW'(r_cmd.root);
    assign lc       = {{(XW - COUNT_W){r_rd.count[COUNT_W-1]}}, r_rd.count};
    assign step     = (!r_cmd.weight[VALUE_W-1] && r_cmd.weight != '0) ? COUNT_W'(1) : '1;

    // read-modify-write of one path node, fresh nodes read as zero
    always_comb begin
        nd        = r_fresh ? '0 : r_rd;
        ch        = bsel ? nd.right : nd.left;
        upd       = nd;
        upd.sum   = nd.sum + r_cmd.weight;
        upd.count = nd.count + step;
        if (r_lvl != '0 && ch == '0) begin
            if (bsel) begin
                upd.right = r_free[NW-1:0];
            end else begin
                upd.left = r_free[NW-1:0];
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_clr        = r_clr;
        n_lvl        = r_lvl;
        n_x          = r_x;
        n_acc        = r_acc;
        n_first      = r_first;
        n_second     = r_second;
        n_right      = r_right;
        n_top        = r_top;
        n_addr       = r_addr;
        n_fresh      = r_fresh;
        n_free       = r_free;
        n_missing    = r_missing;
        n_value      = r_value;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_right;
        w_en         = 1'b0;
        w_addr       = r_addr;
        w_data       = upd;
        o_cmd_pop    = 1'b0;
        fin          = 1'b0;
        fin_acc      = r_acc;
        adv          = 1'b0;
        adv_addr     = r_right;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
                w_data = '0;
                if (r_clr == NW'(KEY_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + NW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_x       = i_cmd.x_a;
                    n_lvl     = LW'(POSITION_BITS);
                    n_acc     = '0;
                    n_second  = 1'b0;
                    n_top     = (i_cmd.op == OP_POS) && ((i_cmd.x_a >> POSITION_BITS) != '0);
                    if (i_cmd.op == OP_NOP) begin
                        n_value  = '0;
                        n_status = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = NW'(i_cmd.root);
                        n_state = S_NODE;
                    end
                end
            end
            S_NODE: begin
                unique case (r_cmd.op)
                    OP_POS: begin
                        if (r_top) begin
                            fin     = 1'b1;
                            fin_acc = r_rd.sum;
                        end else if (bsel && r_rd.left != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = r_rd.left;
                            n_right = r_rd.right;
                            n_state = S_LEFT;
                        end else if (nxt == '0) begin
                            fin = 1'b1;
                        end else begin
                            adv      = 1'b1;
                            adv_addr = nxt;
                        end
                    end
                    OP_RANK: begin
                        if (r_rd.left != '0) begin
                            rd_en   = 1'b1;
                            rd_addr = r_rd.left;
                            n_right = r_rd.right;
                            n_state = S_LEFT;
                        end else if (r_x[XW-1] || r_x == '0 || r_rd.right == '0) begin
                            // empty left side: either the rank lies there or the walk ends
                            fin = 1'b1;
                        end else begin
                            adv      = 1'b1;
                            adv_addr = r_rd.right;
                        end
                    end
                    OP_INSERT: begin
                        // search pass: how many nodes the path still lacks
                        if (nxt == '0) begin
                            n_missing = r_lvl;
                            n_state   = S_CHECK;
                        end else if (r_lvl == LW'(1)) begin
                            n_missing = '0;
                            n_state   = S_CHECK;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = nxt;
                            n_lvl   = r_lvl - LW'(1);
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_LEFT: begin
                // read data now holds the left child
                if (r_cmd.op == OP_RANK && lc >= r_x) begin
                    if (r_lvl == LW'(1)) begin
                        fin = 1'b1;
                    end else begin
                        n_lvl   = r_lvl - LW'(1);
                        n_state = S_NODE;
                    end
                end else begin
                    if (r_cmd.op == OP_RANK) begin
                        n_x = r_x - lc;
                    end
                    n_acc   = r_acc + r_rd.sum;
                    fin_acc = r_acc + r_rd.sum;
                    if (r_right == '0) begin
                        fin = 1'b1;
                    end else begin
                        adv      = 1'b1;
                        adv_addr = r_right;
                    end
                end
            end
            S_CHECK: begin
                if ((NW+2)'(r_free) + (NW+2)'(r_missing) > (NW+2)'(POOL_NODES)) begin
                    n_value  = '0;
                    n_status = 1'b1;
                    n_state  = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = root;
                    n_addr  = root;
                    n_lvl   = LW'(POSITION_BITS);
                    n_fresh = 1'b0;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                w_en   = 1'b1;
                w_addr = r_addr;
                w_data = upd;
                if (r_lvl == '0) begin
                    n_value  = '0;
                    n_status = 1'b0;
                    n_state  = S_DONE;
                end else begin
                    n_lvl = r_lvl - LW'(1);
                    if (ch == '0) begin
                        n_addr  = r_free[NW-1:0];
                        n_free  = r_free + (NW+1)'(1);
                        n_fresh = 1'b1;
                    end else begin
                        n_addr  = ch;
                        n_fresh = 1'b0;
                        rd_en   = 1'b1;
                        rd_addr = ch;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_value;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (adv) begin
            if (r_lvl == LW'(1)) begin
                fin     = 1'b1;
                fin_acc = n_acc;
            end else begin
                rd_en   = 1'b1;
                rd_addr = adv_addr;
                n_lvl   = r_lvl - LW'(1);
                n_state = S_NODE;
            end
        end

        if (fin) begin
            if (!r_second) begin
                // second prefix walk for the lower bound
                n_first  = fin_acc;
                n_second = 1'b1;
                n_x      = r_cmd.x_b;
                n_lvl    = LW'(POSITION_BITS);
                n_acc    = '0;
                n_top    = (r_cmd.op == OP_POS) && ((r_cmd.x_b >> POSITION_BITS) != '0);
                rd_en    = 1'b1;
                rd_addr  = root;
                n_state  = S_NODE;
            end else begin
                n_value  = r_first - fin_acc;
                n_status = 1'b0;
                n_state  = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= (NW+1)'(KEY_COUNT);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_lvl        <= n_lvl;
        r_x          <= n_x;
        r_acc        <= n_acc;
        r_first      <= n_first;
        r_second     <= n_second;
        r_right      <= n_right;
        r_top        <= n_top;
        r_addr       <= n_addr;
        r_fresh      <= n_fresh;
        r_missing    <= n_missing;
        r_value      <= n_value;
        r_status     <= n_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    assign o_clear_done       = (r_state != S_CLEAR);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;

    `KTOSE_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, 1'b1, r_free <= (NW+1)'(POOL_NODES))
    `KTOSE_ASSERT_IMP(a_write_alloc, i_clk, i_rst_n, w_en && r_state != S_CLEAR, {1'b0, w_addr} < r_free)
    `KTOSE_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_cmd_pop, r_state == S_IDLE && i_cmd_valid)
    `KTOSE_ASSERT_NXT(a_done_load, i_clk, i_rst_n, r_state == S_DONE && (!r_out_valid || o_rsp.ready), r_out_valid && r_state == S_IDLE)

endmodule
